/* hdl/wtsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COEF_COUNT = 12;
  localparam int COEF_W     = 32;
  localparam int IDX_W      = 4;
  localparam int MODE_W     = 2;
  localparam int SIZE_W     = 14;

  // matrix layout: row*3+axis, translation row starts at 9
  localparam logic [IDX_W-1:0] TRANS_BASE = 4'd9;

  localparam logic [MODE_W-1:0] MODE_COEF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HUD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISP = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] HUD_WIDTH   = 14'd640;
  localparam logic [SIZE_W-1:0] HUD_HEIGHT  = 14'd480;
  localparam logic [SIZE_W-1:0] DISP_W_RST  = 14'd640;
  localparam logic [SIZE_W-1:0] DISP_H_RST  = 14'd480;

  // accumulator: three floor-shifted products plus translation, exact
  localparam int ACC_W = 66 - FRAC_BITS;
  // divider: |t| * 2^FRAC_BITS
  localparam int DIV_W     = COEF_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 64;

  localparam logic signed [COEF_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SAT,
    ST_CHK,
    ST_DST,
    ST_DIV,
    ST_SCL,
    ST_SCLW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    num;
    logic [COEF_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_W-1:0]    quo;
  } div_rsp_t;

endpackage

/* hdl/world_to_screen_projection.sv */
`timescale 1ns / 1ps
// A projection result is loaded into the output register after nine products, two divides
// and two scalings; zero depth skips the divides and scalings. The next beat is taken only
// after the result is loaded, so a stalled output also holds back the input.
// One shared 32x32 multiplier (nine products, two scalings) and a one-bit-per-cycle divider
// (32 + FRAC_BITS steps, run twice) do this work. Writes and unused modes stay in idle.
// Synchronous active-low reset clears the matrix and sets the display size to 640x480.
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Camera matrix transform, perspective divide and screen scaling of a point.
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coef_index, coef_value, world_x, world_y, world_z, zero pad
  input  logic [wtsp_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode
  input  logic [wtsp_pkg::MODE_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // screen_x, screen_y
  output logic [wtsp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // depth_zero
  output logic                             out_tuser,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [wtsp_pkg::SIZE_W-1:0]      cfg_wdata
);

  localparam int CW = wtsp_pkg::COEF_W;
  localparam int AW = wtsp_pkg::ACC_W;

  wtsp_pkg::state_t state_r, state_nxt;

  logic signed [CW-1:0] coef_r [wtsp_pkg::COEF_COUNT];
  logic [wtsp_pkg::SIZE_W-1:0] dw_r, dh_r;

  logic signed [CW-1:0] wx_r, wy_r, wz_r;
  logic                 hud_r;
  logic [1:0]           row_r, axis_r;
  logic                 coord_r;
  logic signed [AW-1:0] acc_r;
  logic signed [CW-1:0] tx_r, ty_r, tz_r, q_r, sx_r, sy_r;
  logic                 dz_r;

  logic                 out_tvalid_r;
  logic [wtsp_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                 out_tuser_r;

  logic                 in_acc;
  logic [wtsp_pkg::MODE_W-1:0] in_mode;
  logic [wtsp_pkg::IDX_W-1:0]  in_idx;
  logic signed [CW-1:0] in_coef, in_wx, in_wy, in_wz;

  logic                 mul_scale;
  logic                 div_start;
  logic                 out_load;
  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [2*CW-1:0] mul_p;
  logic [wtsp_pkg::IDX_W-1:0] coef_idx;
  logic signed [CW-1:0] w_sel;
  logic [wtsp_pkg::SIZE_W-1:0] size_sel;

  logic signed [CW-1:0] acc_sat, p_sat, q_sat, t_sel;
  logic [CW-1:0]        t_mag, tz_mag;
  logic                 q_neg;
  logic [wtsp_pkg::DIV_W-1:0] quo;

  wtsp_pkg::div_req_t div_req;
  wtsp_pkg::div_rsp_t div_rsp;

  assign in_mode = in_tuser;
  assign in_idx  = in_tdata[3:0];
  assign in_coef = in_tdata[35:4];
  assign in_wx   = in_tdata[67:36];
  assign in_wy   = in_tdata[99:68];
  assign in_wz   = in_tdata[131:100];
  assign in_acc  = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wtsp_pkg::ST_IDLE: begin
        if (in_acc && (in_mode == wtsp_pkg::MODE_HUD || in_mode == wtsp_pkg::MODE_DISP))
          state_nxt = wtsp_pkg::ST_MUL;
      end
      wtsp_pkg::ST_MUL:  state_nxt = wtsp_pkg::ST_ACC;
      wtsp_pkg::ST_ACC:  state_nxt = (row_r == 2'd2) ? wtsp_pkg::ST_SAT : wtsp_pkg::ST_MUL;
      wtsp_pkg::ST_SAT:  state_nxt = (axis_r == 2'd2) ? wtsp_pkg::ST_CHK : wtsp_pkg::ST_MUL;
      wtsp_pkg::ST_CHK:  state_nxt = (tz_r == '0) ? wtsp_pkg::ST_OUT : wtsp_pkg::ST_DST;
      wtsp_pkg::ST_DST:  state_nxt = wtsp_pkg::ST_DIV;
      wtsp_pkg::ST_DIV: begin
        if (div_rsp.done)
          state_nxt = wtsp_pkg::ST_SCL;
      end
      wtsp_pkg::ST_SCL:  state_nxt = wtsp_pkg::ST_SCLW;
      wtsp_pkg::ST_SCLW: state_nxt = coord_r ? wtsp_pkg::ST_OUT : wtsp_pkg::ST_DST;
      wtsp_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready)
          state_nxt = wtsp_pkg::ST_IDLE;
      end
      default: state_nxt = wtsp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    mul_scale = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      wtsp_pkg::ST_IDLE: in_tready = 1'b1;
      wtsp_pkg::ST_SCL:  mul_scale = 1'b1;
      wtsp_pkg::ST_DST:  div_start = 1'b1;
      wtsp_pkg::ST_OUT:  out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= wtsp_pkg::ST_IDLE;
    else
      state_r <= state_nxt;
  end

  // matrix and display size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wtsp_pkg::COEF_COUNT; i++)
        coef_r[i] <= '0;
      dw_r <= wtsp_pkg::DISP_W_RST;
      dh_r <= wtsp_pkg::DISP_H_RST;
    end else begin
      if (in_acc && in_mode == wtsp_pkg::MODE_COEF &&
          in_idx < wtsp_pkg::IDX_W'(wtsp_pkg::COEF_COUNT))
        coef_r[in_idx] <= in_coef;
      if (cfg_we) begin
        case (cfg_addr)
          wtsp_pkg::CFG_WIDTH:  dw_r <= cfg_wdata;
          wtsp_pkg::CFG_HEIGHT: dh_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // shared multiplier operand select
  assign coef_idx = wtsp_pkg::IDX_W'({2'b00, row_r} * 4'd3) + {2'b00, axis_r};

  always_comb begin
    case (row_r)
      2'd0:    w_sel = wx_r;
      2'd1:    w_sel = wy_r;
      default: w_sel = wz_r;
    endcase
  end

  always_comb begin
    if (hud_r)
      size_sel = coord_r ? wtsp_pkg::HUD_HEIGHT : wtsp_pkg::HUD_WIDTH;
    else
      size_sel = coord_r ? dh_r : dw_r;
  end

  assign mul_a = mul_scale ? q_r : w_sel;
  assign mul_b = mul_scale ? signed'({{(CW-wtsp_pkg::SIZE_W){1'b0}}, size_sel})
                           : coef_r[coef_idx];

  wtsp_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // saturation
  always_comb begin
    if (&acc_r[AW-1:CW-1] || ~|acc_r[AW-1:CW-1])
      acc_sat = acc_r[CW-1:0];
    else
      acc_sat = acc_r[AW-1] ? wtsp_pkg::S32_MIN : wtsp_pkg::S32_MAX;
    if (&mul_p[2*CW-1:CW-1] || ~|mul_p[2*CW-1:CW-1])
      p_sat = mul_p[CW-1:0];
    else
      p_sat = mul_p[2*CW-1] ? wtsp_pkg::S32_MIN : wtsp_pkg::S32_MAX;
  end

  // divider operands and quotient sign
  assign t_sel  = coord_r ? ty_r : tx_r;
  assign t_mag  = t_sel[CW-1] ? CW'(-t_sel) : CW'(t_sel);
  assign tz_mag = tz_r[CW-1] ? CW'(-tz_r) : CW'(tz_r);
  assign q_neg  = t_sel[CW-1] ^ tz_r[CW-1];

  assign div_req = {div_start, t_mag, {wtsp_pkg::FRAC_BITS{1'b0}}, tz_mag};

  wtsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign quo = div_rsp.quo;

  always_comb begin
    if (q_neg) begin
      if (|quo[wtsp_pkg::DIV_W-1:CW] || (quo[CW-1] && |quo[CW-2:0]))
        q_sat = wtsp_pkg::S32_MIN;
      else
        q_sat = CW'(-quo[CW-1:0]);
    end else begin
      if (|quo[wtsp_pkg::DIV_W-1:CW-1])
        q_sat = wtsp_pkg::S32_MAX;
      else
        q_sat = quo[CW-1:0];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      wtsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          wx_r    <= in_wx;
          wy_r    <= in_wy;
          wz_r    <= in_wz;
          hud_r   <= (in_mode == wtsp_pkg::MODE_HUD);
          row_r   <= 2'd0;
          axis_r  <= 2'd0;
          coord_r <= 1'b0;
          acc_r   <= AW'(coef_r[wtsp_pkg::TRANS_BASE]);
        end
      end
      wtsp_pkg::ST_ACC: begin
        acc_r <= acc_r + AW'(mul_p >>> wtsp_pkg::FRAC_BITS);
        row_r <= row_r + 2'd1;
      end
      wtsp_pkg::ST_SAT: begin
        case (axis_r)
          2'd0:    tx_r <= acc_sat;
          2'd1:    ty_r <= acc_sat;
          default: tz_r <= acc_sat;
        endcase
        row_r  <= 2'd0;
        axis_r <= axis_r + 2'd1;
        if (axis_r != 2'd2)
          acc_r <= AW'(coef_r[wtsp_pkg::TRANS_BASE + {2'b00, axis_r} + 4'd1]);
      end
      wtsp_pkg::ST_CHK: begin
        coord_r <= 1'b0;
        dz_r    <= (tz_r == '0);
        sx_r    <= '0;
        sy_r    <= '0;
      end
      wtsp_pkg::ST_DIV: begin
        if (div_rsp.done)
          q_r <= q_sat;
      end
      wtsp_pkg::ST_SCLW: begin
        if (coord_r)
          sy_r <= p_sat;
        else
          sx_r <= p_sat;
        coord_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {sy_r, sx_r};
      out_tuser_r <= dz_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* hdl/wtsp_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_mul
// Shared signed 32x32 multiplier with registered 64-bit product.
// ----------------------------------------------------------------------------
module wtsp_mul (
  input  logic                               clk,
  input  logic signed [wtsp_pkg::COEF_W-1:0] a_i,
  input  logic signed [wtsp_pkg::COEF_W-1:0] b_i,
  output logic signed [2*wtsp_pkg::COEF_W-1:0] p_o
);

  logic signed [2*wtsp_pkg::COEF_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a_i * b_i;
  end

  assign p_o = p_r;

endmodule

/* hdl/wtsp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtsp_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wtsp_pkg::div_req_t   req_i,
  output wtsp_pkg::div_rsp_t   rsp_o
);

  logic [wtsp_pkg::DIV_W-1:0]     quo_r;
  logic [wtsp_pkg::COEF_W:0]      rem_r;
  logic [wtsp_pkg::COEF_W-1:0]    den_r;
  logic [wtsp_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [wtsp_pkg::COEF_W:0]      rem_sh;
  logic                           fits;

  assign rem_sh = {rem_r[wtsp_pkg::COEF_W-1:0], quo_r[wtsp_pkg::DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == wtsp_pkg::DIV_CNT_W'(wtsp_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      quo_r <= req_i.num;
      den_r <= req_i.den;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[wtsp_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quo  = quo_r;

endmodule

/* hdl/wtsp_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_chk
// Port-level checks of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
module wtsp_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [wtsp_pkg::MODE_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wtsp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);

  logic in_beat;
  logic proj_beat;

  assign in_beat   = in_tvalid && in_tready;
  assign proj_beat = in_beat &&
                     (in_tuser == wtsp_pkg::MODE_HUD || in_tuser == wtsp_pkg::MODE_DISP);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // zero depth carries zero coordinates
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero depth with nonzero coordinates");

  // a projection occupies the block
  a_proj_busy: assert property (@(posedge clk) disable iff (!rst_n)
    proj_beat |=> !in_tready)
    else $error("input ready right after a projection beat");

  // non-projection beats never block
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !proj_beat |=> in_tready)
    else $error("input stalled after a coefficient write");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind world_to_screen_projection wtsp_chk u_wtsp_chk (.*);
